FILE: hw/rtl/json_comment_stripper_macros.svh
// Assertion helpers, clocked on clk and disabled during reset.
`ifndef JSON_COMMENT_STRIPPER_MACROS_SVH
`define JSON_COMMENT_STRIPPER_MACROS_SVH

`ifndef SYNTHESIS
`define JCS_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define JCS_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define JCS_ASSERT_NOW(lbl, pre, post)
`define JCS_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

FILE: hw/rtl/jcs_pkg.sv
package jcs_pkg;

	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5c;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_last;
	} out_word_t;

	// results of one scan step, up to two words
	typedef struct packed {
		logic [1:0] cnt;
		out_word_t  r0;
		out_word_t  r1;
	} scan_res_t;

endpackage

FILE: hw/rtl/jcs_scan.sv
module jcs_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  jcs_pkg::in_word_t  word,
	input  logic               advance,
	output jcs_pkg::scan_res_t res
);

	typedef enum logic [1:0] {
		MODE_CODE   = 2'd0,
		MODE_STRING = 2'd1,
		MODE_LINE   = 2'd2,
		MODE_BLOCK  = 2'd3
	} mode_t;

	mode_t mode_q, mode_d;
	logic  esc_q, esc_d;
	logic  slash_q, slash_d;
	logic  star_q, star_d;

	logic [7:0] b;
	logic       is_quote;
	logic       is_bsl;

	assign b        = word.in_byte;
	assign is_quote = (b == jcs_pkg::CH_QUOTE);
	assign is_bsl   = (b == jcs_pkg::CH_BSL);

	always_comb begin
		mode_d  = mode_q;
		esc_d   = esc_q;
		slash_d = slash_q;
		star_d  = star_q;
		res     = '0;
		unique case (mode_q)
			MODE_LINE: begin
				if (b == jcs_pkg::CH_NL) begin
					res.r0  = '{out_byte: b, out_valid: 1'b1, out_last: 1'b0};
					res.cnt = 2'd1;
					mode_d  = MODE_CODE;
				end
			end
			MODE_BLOCK: begin
				if (star_q && b == jcs_pkg::CH_SLASH) begin
					mode_d = MODE_CODE;
					star_d = 1'b0;
				end else begin
					star_d = (b == jcs_pkg::CH_STAR);
				end
			end
			MODE_STRING: begin
				if (is_quote && !esc_q)
					mode_d = MODE_CODE;
				esc_d   = is_bsl && !esc_q;
				res.r0  = '{out_byte: b, out_valid: 1'b1, out_last: 1'b0};
				res.cnt = 2'd1;
			end
			MODE_CODE: begin
				if (slash_q) begin
					slash_d = 1'b0;
					if (b == jcs_pkg::CH_SLASH) begin
						mode_d = MODE_LINE;
					end else if (b == jcs_pkg::CH_STAR) begin
						mode_d = MODE_BLOCK;
						star_d = 1'b0;
					end else begin
						// emitted slash clears the escape before b is seen
						res.r0  = '{out_byte: jcs_pkg::CH_SLASH, out_valid: 1'b1,
							out_last: 1'b0};
						res.r1  = '{out_byte: b, out_valid: 1'b1, out_last: 1'b0};
						res.cnt = 2'd2;
						if (is_quote)
							mode_d = MODE_STRING;
						esc_d = is_bsl;
					end
				end else if (b == jcs_pkg::CH_SLASH && !word.in_last) begin
					slash_d = 1'b1;
				end else begin
					if (is_quote && !esc_q)
						mode_d = MODE_STRING;
					esc_d   = is_bsl && !esc_q;
					res.r0  = '{out_byte: b, out_valid: 1'b1, out_last: 1'b0};
					res.cnt = 2'd1;
				end
			end
			default: begin
				mode_d = MODE_CODE;
			end
		endcase

		if (word.in_last) begin
			case (res.cnt)
				2'd0: begin
					res.r0  = '{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b1};
					res.cnt = 2'd1;
				end
				2'd1:    res.r0.out_last = 1'b1;
				default: res.r1.out_last = 1'b1;
			endcase
			mode_d  = MODE_CODE;
			esc_d   = 1'b0;
			slash_d = 1'b0;
			star_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_CODE;
			esc_q   <= 1'b0;
			slash_q <= 1'b0;
			star_q  <= 1'b0;
		end else if (advance) begin
			mode_q  <= mode_d;
			esc_q   <= esc_d;
			slash_q <= slash_d;
			star_q  <= star_d;
		end
	end

endmodule

FILE: hw/rtl/json_comment_stripper.sv
// JSONC comment stripper.
// src channel: one raw text byte per word (in_byte) with in_last on the
// final byte of a stream. snk channel: stripped text bytes (out_byte), with
// out_valid low only on the empty end marker and out_last on the final word.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// Each source word yields zero, one or two sink words. A source word is
// registered, scanned combinationally and written to a two-entry result buffer,
// whose head entry is offered on the sink. One source word is taken per cycle
// while the result buffer has room, and results drain at one per cycle while
// snk_stall is low; a word giving two results (a held slash followed by a plain
// byte) needs both buffer entries. Words that give no result move on without
// using the sink.
// A sink stall fills the result buffer, then the input register, then raises
// src_stall. Reset empties both and returns the scanner to code mode.
`include "json_comment_stripper_macros.svh"

module json_comment_stripper (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  jcs_pkg::in_word_t   src_word,
	output logic                snk_valid,
	input  logic                snk_stall,
	output jcs_pkg::out_word_t  snk_word
);

	logic               valid_s1;
	jcs_pkg::in_word_t  word_s1;
	jcs_pkg::scan_res_t res;
	logic               move;
	logic               take;
	logic [1:0]         cnt_q;
	logic [1:0]         cnt_rem;
	logic [2:0]         need;
	jcs_pkg::out_word_t ent0_q;
	jcs_pkg::out_word_t ent1_q;

	jcs_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.word    (word_s1),
		.advance (move),
		.res     (res)
	);

	assign snk_valid = (cnt_q != 2'd0);
	assign snk_word  = ent0_q;
	assign take      = snk_valid && !snk_stall;
	assign cnt_rem   = cnt_q - {1'b0, take};
	assign need      = {1'b0, cnt_rem} + {1'b0, res.cnt};
	assign move      = valid_s1 && (need <= 3'd2);
	assign src_stall = valid_s1 && !move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!src_stall && src_valid)
			word_s1 <= src_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (move) begin
			cnt_q <= need[1:0];
		end else begin
			cnt_q <= cnt_rem;
		end
	end

	always_ff @(posedge clk) begin
		if (take && cnt_q == 2'd2)
			ent0_q <= ent1_q;
		if (move) begin
			if (cnt_rem == 2'd0) begin
				ent0_q <= res.r0;
				ent1_q <= res.r1;
			end else if (cnt_rem == 2'd1) begin
				ent1_q <= res.r0;
			end
		end
	end

	`JCS_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q != 2'd3)
	`JCS_ASSERT_NOW(a_empty_is_last, snk_valid && !snk_word.out_valid, snk_word.out_last)
	`JCS_ASSERT_NEXT(a_snk_hold, snk_valid && snk_stall, snk_valid && $stable(snk_word))
	`JCS_ASSERT_NEXT(a_full_holds, cnt_q == 2'd2 && snk_stall, cnt_q == 2'd2)

endmodule

FILE: tb/json_comment_stripper_test.sv
`timescale 1ns / 100ps

typedef enum logic [1:0] {
	SCAN_CODE,
	SCAN_STRING,
	SCAN_LINE,
	SCAN_BLOCK
} scan_mode_t;

class strip_scoreboard;
	scan_mode_t         mode;
	bit                 esc;
	bit                 slash_wait;
	bit                 star_wait;
	jcs_pkg::out_word_t stripped_q[$];
	int                 errors;

	function new();
		errors = 0;
		clear_state();
	endfunction

	function void clear_state();
		mode = SCAN_CODE;
		esc = 1'b0;
		slash_wait = 1'b0;
		star_wait = 1'b0;
	endfunction

	function void push_word(logic [7:0] c, logic v);
		jcs_pkg::out_word_t w;
		w.out_byte = c;
		w.out_valid = v;
		w.out_last = 1'b0;
		stripped_q = {stripped_q, w};
	endfunction

	// code or string byte passed through; tracks quotes and escapes
	function void pass_on(logic [7:0] c);
		if (c == jcs_pkg::CH_QUOTE && !esc)
			mode = (mode == SCAN_STRING) ? SCAN_CODE : SCAN_STRING;
		esc = (c == jcs_pkg::CH_BSL) && !esc;
		push_word(c, 1'b1);
	endfunction

	function void note_word(jcs_pkg::in_word_t w);
		int         base;
		logic [7:0] b;
		base = stripped_q.size();
		b = w.in_byte;
		case (mode)
			SCAN_LINE: begin
				if (b == jcs_pkg::CH_NL) begin
					push_word(b, 1'b1);
					mode = SCAN_CODE;
				end
			end
			SCAN_BLOCK: begin
				if (star_wait && b == jcs_pkg::CH_SLASH) begin
					mode = SCAN_CODE;
					star_wait = 1'b0;
				end else begin
					star_wait = (b == jcs_pkg::CH_STAR);
				end
			end
			SCAN_STRING: begin
				pass_on(b);
			end
			default: begin
				if (slash_wait) begin
					slash_wait = 1'b0;
					if (b == jcs_pkg::CH_SLASH) begin
						mode = SCAN_LINE;
					end else if (b == jcs_pkg::CH_STAR) begin
						mode = SCAN_BLOCK;
						star_wait = 1'b0;
					end else begin
						pass_on(jcs_pkg::CH_SLASH);
						pass_on(b);
					end
				end else if (b == jcs_pkg::CH_SLASH && !w.in_last) begin
					slash_wait = 1'b1;
				end else begin
					pass_on(b);
				end
			end
		endcase
		if (w.in_last) begin
			if (stripped_q.size() == base)
				push_word(8'h00, 1'b0);
			stripped_q[stripped_q.size() - 1].out_last = 1'b1;
			clear_state();
		end
	endfunction

	task report_mismatch(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	task check_word(jcs_pkg::out_word_t got);
		jcs_pkg::out_word_t want;
		if (stripped_q.size() == 0) begin
			report_mismatch($sformatf("unexpected word %h", got));
			return;
		end
		want = stripped_q.pop_front();
		if (got.out_byte !== want.out_byte)
			report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
		if (got.out_valid !== want.out_valid)
			report_mismatch($sformatf("out_valid %b, want %b", got.out_valid, want.out_valid));
		if (got.out_last !== want.out_last)
			report_mismatch($sformatf("out_last %b, want %b", got.out_last, want.out_last));
	endtask
endclass

module json_comment_stripper_test;

	localparam int RANDOM_WORDS = 1750;
	localparam int STALL_LIMIT  = 4000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               src_valid = 1'b0;
	logic               src_stall;
	jcs_pkg::in_word_t  src_word = '0;
	logic               snk_valid;
	logic               snk_stall = 1'b0;
	jcs_pkg::out_word_t snk_word;

	strip_scoreboard   sb;
	jcs_pkg::in_word_t stim[$];
	int                fed = 0;
	int                quiet_cycles = 0;

	json_comment_stripper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_word (src_word),
		.snk_valid(snk_valid),
		.snk_stall(snk_stall),
		.snk_word (snk_word)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task add(logic [7:0] c, logic last_flag);
		jcs_pkg::in_word_t w;
		w.in_byte = c;
		w.in_last = last_flag;
		stim = {stim, w};
	endtask

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return 8'($urandom_range(0, 255));
		if (r < 45) return jcs_pkg::CH_SLASH;
		if (r < 58) return jcs_pkg::CH_STAR;
		if (r < 70) return jcs_pkg::CH_QUOTE;
		if (r < 78) return jcs_pkg::CH_BSL;
		if (r < 88) return jcs_pkg::CH_NL;
		return 8'($urandom_range(8'h61, 8'h7a));
	endfunction

	// sender idles 27/receiver 78, then swapped, then no idling
	function automatic int idle_pct(bit rx);
		if (fed < stim.size() / 3) return rx ? 78 : 27;
		if (fed < 2 * stim.size() / 3) return rx ? 27 : 78;
		return 0;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (src_valid && !src_stall) begin
				sb.note_word(src_word);
				fed++;
			end
			if (!src_valid || !src_stall) begin
				if (fed < stim.size() && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
					src_valid <= 1'b1;
					src_word <= stim[fed];
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (snk_valid && !snk_stall)
				sb.check_word(snk_word);
			snk_stall <= ($urandom_range(0, 99) < idle_pct(1'b1));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((src_valid && !src_stall) || (snk_valid && !snk_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL json_comment_stripper");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		// single last byte, top byte value
		add(8'h00, 1'b1);
		add(8'hff, 1'b0);
		// held slash then plain byte
		add(jcs_pkg::CH_SLASH, 1'b0);
		add("a", 1'b0);
		// line comment keeps its newline
		add(jcs_pkg::CH_SLASH, 1'b0);
		add(jcs_pkg::CH_SLASH, 1'b0);
		add("c", 1'b0);
		add(jcs_pkg::CH_NL, 1'b0);
		// slash star slash stays inside, star star slash closes
		add(jcs_pkg::CH_SLASH, 1'b0);
		add(jcs_pkg::CH_STAR, 1'b0);
		add(jcs_pkg::CH_SLASH, 1'b0);
		add(jcs_pkg::CH_STAR, 1'b0);
		add(jcs_pkg::CH_STAR, 1'b0);
		add(jcs_pkg::CH_SLASH, 1'b0);
		// string with slashes and an escaped quote
		add(jcs_pkg::CH_QUOTE, 1'b0);
		add(jcs_pkg::CH_SLASH, 1'b0);
		add(jcs_pkg::CH_SLASH, 1'b0);
		add(jcs_pkg::CH_BSL, 1'b0);
		add(jcs_pkg::CH_QUOTE, 1'b0);
		add(jcs_pkg::CH_QUOTE, 1'b0);
		// escaped quote in code
		add(jcs_pkg::CH_BSL, 1'b0);
		add(jcs_pkg::CH_QUOTE, 1'b0);
		// comment opened on the last byte
		add(jcs_pkg::CH_SLASH, 1'b0);
		add(jcs_pkg::CH_SLASH, 1'b1);
		// lone slash as last byte
		add(jcs_pkg::CH_SLASH, 1'b1);
		for (int i = 0; i < RANDOM_WORDS; i++)
			add(pick_char(), (i == RANDOM_WORDS - 1) || ($urandom_range(0, 49) == 0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(negedge clk);
		while (fed < stim.size() || sb.stripped_q.size() != 0);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.stripped_q.size() == 0)
			$display("PASS json_comment_stripper");
		else
			$display("FAIL json_comment_stripper");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/jcs_pkg.sv
hw/rtl/jcs_scan.sv
hw/rtl/json_comment_stripper.sv
tb/json_comment_stripper_test.sv
